FILE: hw/rtl/palette_gradient_table_top_assert.svh
// ----------------------------------------------------------------------------
// Palette gradient table assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PALETTE_GRADIENT_TABLE_TOP_ASSERT_SVH
`define PALETTE_GRADIENT_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PGT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PGT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PGT_ASSERT_IMPL(lbl, ante, cons, msg)
`define PGT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/pgt_pkg.sv
// ----------------------------------------------------------------------------
// Palette gradient table package
// Field widths, stream and register port sizes, opcodes and entry types.
// ----------------------------------------------------------------------------
package pgt_pkg;

	// field widths
	localparam int OPC_W     = 3;
	localparam int IDX_W     = 8;
	localparam int CH_W      = 8;
	localparam int CNT_W     = 9;
	localparam int DIV_CNT_W = 3;

	// stream payload sizes
	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 40;

	// register port sizes
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register map: index taken from paddr[2]
	localparam logic REG_NUM_COLORS = 1'b0;

	// last step of the per-channel restoring divider
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(CH_W - 1);

	typedef enum logic [OPC_W-1:0] {
		OP_WRITE  = 3'd0,
		OP_READ   = 3'd1,
		OP_FILL   = 3'd2,
		OP_INVERT = 3'd3,
		OP_MAX    = 3'd4
	} op_t;

	// one palette entry, red in the low byte
	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	// one result
	typedef struct packed {
		rgb_t            color;
		logic            ok;
		logic [CH_W-1:0] maxc;
	} res_t;

	function automatic logic [CH_W-1:0] max_u8(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

FILE: hw/rtl/palette_gradient_table_top.sv
// ----------------------------------------------------------------------------
// Palette gradient table
// Write and rejected requests complete on acceptance; read and invert read the
// entry first; gradient fill runs 8 divider steps, then one memory write per entry;
// max query does one memory read per entry in use. One request at a time.
// Reset clears every entry; a count write clears from the new count up.
// Requests wait for the clear.
// ----------------------------------------------------------------------------
`include "palette_gradient_table_top_assert.svh"

module palette_gradient_table_top #(
	parameter int ENTRIES = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pgt_pkg::APB_AW-1:0]       paddr,
	input  logic [pgt_pkg::APB_DW-1:0]       pwdata,
	output logic [pgt_pkg::APB_DW-1:0]       prdata,
	output logic                             pready,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// index, end_index, start_red, start_green, start_blue,
	// end_red, end_green, end_blue, invert_max
	input  logic [pgt_pkg::IN_TDATA_W-1:0]   s_tdata,
	// opcode
	input  logic [pgt_pkg::IN_TUSER_W-1:0]   s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// red, green, blue, done_ok, max_channel, zero pad
	output logic [pgt_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import pgt_pkg::*;

	localparam int AW      = $clog2(ENTRIES);
	localparam int CW      = $clog2(ENTRIES + 1);
	localparam int XW      = (CW > CNT_W) ? CW : CNT_W;
	localparam int RST_CNT = (ENTRIES < 256) ? ENTRIES : 256;
	localparam logic [XW-1:0] ENT_X = XW'(ENTRIES);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_INV, S_DIV, S_FILL, S_MAX, S_RESP
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         num_q;
	logic [CW-1:0]         ptr_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic                  m_tvalid_q;
	res_t                  out_q;
	res_t                  res_q;

	// request fields held for the duration of the operation
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      eidx_q;
	logic [IDX_W-1:0]      span_q;
	logic [CH_W-1:0]       mx_q;
	logic [CH_W-1:0]       st_q   [3];
	logic                  neg_q  [3];
	logic [CH_W-1:0]       rem_q  [3];
	logic [CH_W-1:0]       quo_q  [3];
	logic [CH_W-1:0]       v_q    [3];
	logic [CH_W-1:0]       racc_q [3];
	logic [CH_W-1:0]       max_q;

	// palette memory
	rgb_t                  mem [ENTRIES];
	rgb_t                  rdata_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	rgb_t                  mem_wdata;
	logic [AW-1:0]         mem_raddr;

	// decoded request
	logic                  cfg_wr;
	logic                  cfg_hit;
	logic [XW-1:0]         cfg_raw;
	logic [XW-1:0]         cfg_cnt;
	logic                  in_acc;
	op_t                   in_op;
	logic [IDX_W-1:0]      in_idx;
	logic [IDX_W-1:0]      in_eidx;
	logic [CH_W-1:0]       in_mx;
	logic [CH_W-1:0]       in_st [3];
	logic [CH_W-1:0]       in_en [3];
	logic [XW-1:0]         idx_x;
	logic [XW-1:0]         eidx_x;
	logic [XW-1:0]         num_x;
	logic [XW-1:0]         ptr_x;
	logic [XW-1:0]         idx_hx;
	logic                  in_valid;
	logic                  grad_ok;
	logic                  inv_ok;
	logic                  slot_free;
	logic                  fin;
	res_t                  fin_res;
	logic                  out_load;
	res_t                  out_next;
	logic                  fill_ptr_ok;
	logic                  max_ptr_ok;

	// divider and ramp step
	logic [CH_W:0]         trial  [3];
	logic                  ge     [3];
	logic [CH_W-1:0]       rem_n  [3];
	logic [CH_W-1:0]       quo_n  [3];
	logic [CH_W-1:0]       q0     [3];
	logic [CH_W-1:0]       r0     [3];
	logic [CH_W:0]         rsum   [3];
	logic [CH_W-1:0]       v_n    [3];
	logic [CH_W-1:0]       racc_n [3];
	logic [CH_W-1:0]       max_n;

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_hit = cfg_wr && (paddr[2] == REG_NUM_COLORS);
	assign cfg_raw = XW'(pwdata[CNT_W-1:0]);
	assign cfg_cnt = (cfg_raw > ENT_X) ? ENT_X : cfg_raw;
	assign prdata  = (paddr[2] == REG_NUM_COLORS) ? APB_DW'(num_q) : '0;

	// request unpacking
	assign in_op    = op_t'(s_tuser);
	assign in_idx   = s_tdata[7:0];
	assign in_eidx  = s_tdata[15:8];
	assign in_st[0] = s_tdata[23:16];
	assign in_st[1] = s_tdata[31:24];
	assign in_st[2] = s_tdata[39:32];
	assign in_en[0] = s_tdata[47:40];
	assign in_en[1] = s_tdata[55:48];
	assign in_en[2] = s_tdata[63:56];
	assign in_mx    = s_tdata[71:64];

	assign s_tready = (state_q == S_IDLE) && !cfg_wr;
	assign in_acc   = s_tvalid && s_tready;

	assign idx_x    = XW'(in_idx);
	assign eidx_x   = XW'(in_eidx);
	assign num_x    = XW'(num_q);
	assign ptr_x    = XW'(ptr_q);
	assign idx_hx   = XW'(idx_q);
	assign in_valid = idx_x < num_x;
	assign grad_ok  = (in_idx < in_eidx) && (eidx_x < num_x);
	assign inv_ok   = (rdata_q.red <= mx_q) && (rdata_q.green <= mx_q) &&
		(rdata_q.blue <= mx_q);
	assign slot_free = !m_tvalid_q || m_tready;

	// divider step, floor quotient/remainder of (end-start)/span, ramp step
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			trial[c] = {rem_q[c], quo_q[c][CH_W-1]};
			ge[c]    = trial[c] >= {1'b0, span_q};
			rem_n[c] = ge[c] ? CH_W'(trial[c] - {1'b0, span_q}) : trial[c][CH_W-1:0];
			quo_n[c] = {quo_q[c][CH_W-2:0], ge[c]};
			if (!neg_q[c]) begin
				q0[c] = quo_q[c];
				r0[c] = rem_q[c];
			end else if (rem_q[c] == '0) begin
				q0[c] = ~quo_q[c] + 1'b1;
				r0[c] = '0;
			end else begin
				q0[c] = ~quo_q[c];
				r0[c] = span_q - rem_q[c];
			end
			rsum[c] = {1'b0, racc_q[c]} + {1'b0, r0[c]};
			if (rsum[c] >= {1'b0, span_q}) begin
				racc_n[c] = CH_W'(rsum[c] - {1'b0, span_q});
				v_n[c]    = v_q[c] + q0[c] + 1'b1;
			end else begin
				racc_n[c] = rsum[c][CH_W-1:0];
				v_n[c]    = v_q[c] + q0[c];
			end
		end
		max_n = max_u8(max_q, max_u8(rdata_q.red, max_u8(rdata_q.green, rdata_q.blue)));
	end

	// memory access and completion per state
	always_comb begin
		fin       = 1'b0;
		fin_res   = '0;
		mem_we    = 1'b0;
		mem_waddr = ptr_q[AW-1:0];
		mem_wdata = '0;
		mem_raddr = (in_op == OP_MAX) ? '0 : idx_x[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we = ptr_x < ENT_X;
			end
			S_IDLE: begin
				if (in_acc) begin
					case (in_op)
						OP_WRITE: begin
							fin = 1'b1;
							if (in_valid) begin
								mem_we      = 1'b1;
								mem_waddr   = idx_x[AW-1:0];
								mem_wdata   = '{blue: in_st[2], green: in_st[1],
									red: in_st[0]};
								fin_res.ok  = 1'b1;
							end
						end
						OP_READ, OP_INVERT: begin
							fin = !in_valid;
						end
						OP_FILL: begin
							fin = !grad_ok;
						end
						OP_MAX: begin
							fin        = (num_q == '0);
							fin_res.ok = 1'b1;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				fin           = 1'b1;
				fin_res.color = rdata_q;
				fin_res.ok    = 1'b1;
			end
			S_INV: begin
				fin = 1'b1;
				if (inv_ok) begin
					mem_we     = 1'b1;
					mem_waddr  = idx_hx[AW-1:0];
					mem_wdata  = '{blue: mx_q - rdata_q.blue, green: mx_q - rdata_q.green,
						red: mx_q - rdata_q.red};
					fin_res.ok = 1'b1;
				end
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = '{blue: v_q[2], green: v_q[1], red: v_q[0]};
				if (ptr_x == XW'(eidx_q)) begin
					fin        = 1'b1;
					fin_res.ok = 1'b1;
				end
			end
			S_MAX: begin
				mem_raddr = ptr_q[AW-1:0];
				if (ptr_x == num_x) begin
					fin          = 1'b1;
					fin_res.ok   = 1'b1;
					fin_res.maxc = max_n;
				end
			end
			default: begin
			end
		endcase
	end

	// palette memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[mem_raddr];
	end

	// output register load, from a fresh completion or a held result
	assign out_load = slot_free && (fin || (state_q == S_RESP));
	assign out_next = fin ? fin_res : res_q;

	// sequencer, count register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ptr_q      <= '0;
			num_q      <= CW'(RST_CNT);
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
			out_q      <= '0;
			res_q      <= '0;
		end else begin
			if (out_load) begin
				out_q      <= out_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (fin && !slot_free) begin
				res_q <= fin_res;
			end
			// count write: clear from the lower of the new count and a sweep in progress
			if (cfg_hit) begin
				num_q   <= cfg_cnt[CW-1:0];
				state_q <= S_CLEAR;
				ptr_q   <= ((state_q == S_CLEAR) && (ptr_x < cfg_cnt)) ? ptr_q :
					cfg_cnt[CW-1:0];
			end else if (fin) begin
				if (slot_free) begin
					state_q <= S_IDLE;
				end else begin
					state_q <= S_RESP;
				end
			end else begin
				case (state_q)
					S_CLEAR: begin
						if (ptr_x < ENT_X) begin
							ptr_q <= ptr_q + 1'b1;
						end else begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (in_acc) begin
							case (in_op)
								OP_READ:   state_q <= S_READ;
								OP_INVERT: state_q <= S_INV;
								OP_FILL: begin
									state_q   <= S_DIV;
									div_cnt_q <= '0;
								end
								OP_MAX: begin
									state_q <= S_MAX;
									ptr_q   <= CW'(1);
								end
								default: state_q <= S_IDLE;
							endcase
						end
					end
					S_DIV: begin
						div_cnt_q <= div_cnt_q + 1'b1;
						if (div_cnt_q == DIV_LAST) begin
							state_q <= S_FILL;
							ptr_q   <= idx_hx[CW-1:0];
						end
					end
					S_FILL, S_MAX: begin
						ptr_q <= ptr_q + 1'b1;
					end
					S_RESP: begin
						if (slot_free) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// operation datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q  <= in_idx;
			eidx_q <= in_eidx;
			span_q <= in_eidx - in_idx;
			mx_q   <= in_mx;
			max_q  <= '0;
			for (int c = 0; c < 3; c++) begin
				st_q[c]  <= in_st[c];
				neg_q[c] <= in_en[c] < in_st[c];
				quo_q[c] <= (in_en[c] < in_st[c]) ? in_st[c] - in_en[c] : in_en[c] - in_st[c];
				rem_q[c] <= '0;
			end
		end
		case (state_q)
			S_DIV: begin
				for (int c = 0; c < 3; c++) begin
					rem_q[c] <= rem_n[c];
					quo_q[c] <= quo_n[c];
					if (div_cnt_q == DIV_LAST) begin
						v_q[c]    <= st_q[c];
						racc_q[c] <= '0;
					end
				end
			end
			S_FILL: begin
				for (int c = 0; c < 3; c++) begin
					v_q[c]    <= v_n[c];
					racc_q[c] <= racc_n[c];
				end
			end
			S_MAX: begin
				max_q <= max_n;
			end
			default: begin
			end
		endcase
	end

	// result stream
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, out_q.maxc, out_q.ok, out_q.color.blue, out_q.color.green,
		out_q.color.red};

	// checks
	assign fill_ptr_ok = (ptr_x >= idx_hx) && (ptr_x <= XW'(eidx_q)) && (XW'(eidx_q) < num_x);
	assign max_ptr_ok  = (ptr_x <= num_x) && (ptr_q != '0);
	`PGT_ASSERT_NEXT(a_acc_tracked, in_acc, m_tvalid_q || (state_q != S_IDLE), "request lost")
	`PGT_ASSERT_IMPL(a_rise_src, $rose(m_tvalid_q), $past(fin || (state_q == S_RESP)), "no source")
	`PGT_ASSERT_IMPL(a_fill_range, state_q == S_FILL, fill_ptr_ok, "fill pointer out of range")
	`PGT_ASSERT_IMPL(a_max_range, state_q == S_MAX, max_ptr_ok, "max walk pointer out of range")

endmodule

FILE: tb/palette_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette result checker
// Follows the count register and both streams, keeps a shadow palette, works
// out the answer to every accepted request and matches it against the results
// in order, field by field.
// ----------------------------------------------------------------------------
module palette_result_check #(
	parameter int ENTRIES = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pgt_pkg::APB_AW-1:0]       paddr,
	input  logic [pgt_pkg::APB_DW-1:0]       pwdata,
	input  logic                             pready,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// index, end_index, start_red, start_green, start_blue,
	// end_red, end_green, end_blue, invert_max
	input  logic [pgt_pkg::IN_TDATA_W-1:0]   s_tdata,
	// opcode
	input  logic [pgt_pkg::IN_TUSER_W-1:0]   s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// red, green, blue, done_ok, max_channel, zero pad
	input  logic [pgt_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output int                               errors,
	output int                               pending
);
	import pgt_pkg::*;

	typedef struct {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            ok;
		logic [CH_W-1:0] maxc;
	} reply_t;

	rgb_t        shadow [ENTRIES];
	int unsigned in_use = ENTRIES;
	reply_t      replies_due [$];
	int          bad = 0;

	// start + floor(k * (end - start) / span), kept non-negative
	function automatic logic [CH_W-1:0] ramp_level(input int unsigned s, e, k, span);
		return CH_W'((s * (span - k) + e * k) / span);
	endfunction

	function automatic int field_miss(input string name, input logic [CH_W-1:0] want,
		input logic [CH_W-1:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		return 1;
	endfunction

	// apply one request to the shadow palette and queue its answer
	task automatic predict(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] a, z,
		input rgb_t from, to, input logic [CH_W-1:0] cap);
		reply_t      r;
		rgb_t        cur;
		int unsigned span;
		int unsigned k;
		r = '{default: '0};
		cur = shadow[a];
		case (op)
			OP_WRITE: begin
				if (a < in_use) begin
					shadow[a] = from;
					r.ok = 1'b1;
				end
			end
			OP_READ: begin
				if (a < in_use) begin
					r.red = cur.red;
					r.green = cur.green;
					r.blue = cur.blue;
					r.ok = 1'b1;
				end
			end
			OP_FILL: begin
				// both ends inside the palette, end strictly after start
				if (a < z && z < in_use) begin
					span = z - a;
					for (k = 0; k <= span; k++) begin
						shadow[a + k].red = ramp_level(from.red, to.red, k, span);
						shadow[a + k].green = ramp_level(from.green, to.green, k, span);
						shadow[a + k].blue = ramp_level(from.blue, to.blue, k, span);
					end
					r.ok = 1'b1;
				end
			end
			OP_INVERT: begin
				// any channel above the cap leaves the entry alone
				if (a < in_use && cur.red <= cap && cur.green <= cap && cur.blue <= cap) begin
					shadow[a].red = cap - cur.red;
					shadow[a].green = cap - cur.green;
					shadow[a].blue = cap - cur.blue;
					r.ok = 1'b1;
				end
			end
			OP_MAX: begin
				for (k = 0; k < in_use; k++) begin
					if (shadow[k].red > r.maxc) r.maxc = shadow[k].red;
					if (shadow[k].green > r.maxc) r.maxc = shadow[k].green;
					if (shadow[k].blue > r.maxc) r.maxc = shadow[k].blue;
				end
				r.ok = 1'b1;
			end
			default: ;
		endcase
		replies_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		int unsigned k;
		reply_t      want;
		if (!arst_n) begin
			in_use = ENTRIES;
			for (k = 0; k < ENTRIES; k++)
				shadow[k] = '0;
			replies_due.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			// count write: clamp, then clear everything from the new count up
			if (psel && penable && pwrite && pready && paddr[2] == REG_NUM_COLORS) begin
				in_use = (pwdata[CNT_W-1:0] > ENTRIES) ? ENTRIES : pwdata[CNT_W-1:0];
				for (k = in_use; k < ENTRIES; k++)
					shadow[k] = '0;
			end
			if (s_tvalid && s_tready)
				predict(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[39:16],
					s_tdata[63:40], s_tdata[71:64]);
			if (m_tvalid && m_tready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: result with no request pending, expected none, actual %h",
						$time, m_tdata);
					bad++;
				end else begin
					want = replies_due.pop_front();
					bad += field_miss("red", want.red, m_tdata[7:0]);
					bad += field_miss("green", want.green, m_tdata[15:8]);
					bad += field_miss("blue", want.blue, m_tdata[23:16]);
					bad += field_miss("done_ok", CH_W'(want.ok), CH_W'(m_tdata[24]));
					bad += field_miss("max_channel", want.maxc, m_tdata[32:25]);
				end
			end
			errors <= bad;
			pending <= replies_due.size();
		end
	end

endmodule

FILE: tb/palette_gradient_table_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette gradient table testbench
// Directed requests over the edge cases, then random request mixes under a
// run of palette counts, with random idling on both streams and a long output
// hold-off. Results are checked by the palette result checker.
// ----------------------------------------------------------------------------
module palette_gradient_table_top_test;
	import pgt_pkg::*;

	localparam int ENTRIES        = 256;
	localparam int IDLE_PCT       = 38;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_EVERY     = 650;
	// longest quiet stretch in a good run: hold-off plus a full fill or query
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 110;
	localparam logic [OPC_W-1:0]  SPARE_OP_FIRST  = 3'd5;
	localparam logic [OPC_W-1:0]  SPARE_OP_LAST   = 3'd7;
	localparam logic [APB_AW-1:0] NUM_COLORS_ADDR = APB_AW'(4 * int'(REG_NUM_COLORS));

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_AW-1:0]      paddr = '0;
	logic [APB_DW-1:0]      pwdata = '0;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	int                     errors;
	int                     pending;
	int unsigned            cur_count = ENTRIES;
	bit                     calm = 1'b0;
	int                     results_taken = 0;
	int                     quiet_cycles = 0;
	int                     hold_left = 0;
	int                     next_hold_at = 150;

	always #2 clk = ~clk;

	palette_gradient_table_top #(
		.ENTRIES(ENTRIES)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	palette_result_check #(
		.ENTRIES(ENTRIES)
	) u_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	// result count and watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				results_taken <= results_taken + 1;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("palette_gradient_table_top regression: fail");
				$finish;
			end
		end
	end

	// result side: random idling, plus a long hold-off every HOLD_EVERY results
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else if (results_taken == next_hold_at) begin
			m_tready = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			next_hold_at += HOLD_EVERY;
		end else begin
			m_tready = calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// one request; colors are packed blue, green, red with red lowest
	task automatic send_request(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] a, z,
		input rgb_t from, to, input logic [CH_W-1:0] cap);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {cap, to, from, z, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// count write once the block has gone quiet and its clearing sweep is over
	task automatic write_count(input logic [APB_DW-1:0] word);
		s_tvalid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (ENTRIES + 16) @(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = NUM_COLORS_ADDR;
		pwdata = word;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		cur_count = (word[CNT_W-1:0] > ENTRIES) ? ENTRIES : word[CNT_W-1:0];
	endtask

	// mostly in-range indexes and short gradients, with some noise
	task automatic send_random();
		int                unsigned pick;
		logic [OPC_W-1:0]  op;
		logic [IDX_W-1:0]  a;
		logic [IDX_W-1:0]  z;
		logic [CH_W-1:0]   cap;
		pick = $urandom_range(99);
		if (pick < 24)
			op = OP_WRITE;
		else if (pick < 48)
			op = OP_READ;
		else if (pick < 64)
			op = OP_FILL;
		else if (pick < 84)
			op = OP_INVERT;
		else if (pick < 92)
			op = OP_MAX;
		else
			op = OPC_W'($urandom_range(SPARE_OP_LAST, SPARE_OP_FIRST));
		if (cur_count != 0 && $urandom_range(3) != 0)
			a = IDX_W'($urandom_range(cur_count - 1));
		else
			a = IDX_W'($urandom);
		if ($urandom_range(3) == 0)
			z = IDX_W'($urandom);
		else
			z = a + IDX_W'($urandom_range(8, 1));
		cap = ($urandom_range(3) == 0) ? 8'hff : CH_W'($urandom);
		send_request(op, a, z, rgb_t'($urandom), rgb_t'($urandom), cap);
	endtask

	initial begin
		logic [APB_DW-1:0] word;
		int                items;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// full palette: writes, reads, invert, gradients, max queries and spare opcodes
		write_count(ENTRIES);
		send_request(OP_MAX, 8'd0, 8'd0, 24'h000000, 24'h000000, 8'h00);
		send_request(OP_WRITE, 8'd0, 8'd0, 24'h563412, 24'h000000, 8'h00);
		send_request(OP_WRITE, 8'd255, 8'd0, 24'hffffff, 24'h000000, 8'h00);
		send_request(OP_READ, 8'd0, 8'd0, 24'h000000, 24'h000000, 8'h00);
		send_request(OP_READ, 8'd255, 8'd0, 24'h000000, 24'h000000, 8'h00);
		send_request(OP_MAX, 8'd0, 8'd0, 24'h000000, 24'h000000, 8'h00);
		send_request(OP_INVERT, 8'd255, 8'd0, 24'h000000, 24'h000000, 8'hff);
		// blue 0x56 is above the cap, so this one is refused
		send_request(OP_INVERT, 8'd0, 8'd0, 24'h000000, 24'h000000, 8'h40);
		send_request(OP_INVERT, 8'd0, 8'd0, 24'h000000, 24'h000000, 8'h56);
		send_request(OP_FILL, 8'd0, 8'd255, 24'h00ff00, 24'hff00ff, 8'h00);
		send_request(OP_READ, 8'd128, 8'd0, 24'h000000, 24'h000000, 8'h00);
		send_request(OP_FILL, 8'd10, 8'd10, 24'hffffff, 24'hffffff, 8'h00);
		send_request(OP_FILL, 8'd20, 8'd10, 24'hffffff, 24'hffffff, 8'h00);
		send_request(OP_FILL, 8'd254, 8'd255, 24'hffffff, 24'h000000, 8'h00);
		send_request(OP_READ, 8'd254, 8'd0, 24'h000000, 24'h000000, 8'h00);
		send_request(SPARE_OP_FIRST, 8'hff, 8'hff, 24'hffffff, 24'hffffff, 8'hff);
		send_request(OP_MAX, 8'd0, 8'd0, 24'h000000, 24'h000000, 8'h00);

		// single entry: index 1 and the gradient past the end are refused
		write_count(32'd1);
		send_request(OP_WRITE, 8'd1, 8'd0, 24'h123456, 24'h000000, 8'h00);
		send_request(OP_READ, 8'd1, 8'd0, 24'h000000, 24'h000000, 8'h00);
		send_request(OP_INVERT, 8'd1, 8'd0, 24'h000000, 24'h000000, 8'hff);
		send_request(OP_FILL, 8'd0, 8'd1, 24'hffffff, 24'h000000, 8'h00);
		send_request(OP_INVERT, 8'd0, 8'd0, 24'h000000, 24'h000000, 8'hff);
		send_request(OP_MAX, 8'd0, 8'd0, 24'h000000, 24'h000000, 8'h00);

		// empty palette, then an oversized count with junk in the upper bits
		write_count(32'd0);
		send_request(OP_MAX, 8'd0, 8'd0, 24'h000000, 24'h000000, 8'h00);
		send_request(OP_WRITE, 8'd0, 8'd0, 24'hffffff, 24'h000000, 8'h00);
		write_count(32'ha5a5_a1ff);
		send_request(OP_READ, 8'd255, 8'd0, 24'h000000, 24'h000000, 8'h00);
		send_request(OP_MAX, 8'd0, 8'd0, 24'h000000, 24'h000000, 8'h00);

		// random mixes over a run of counts
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 6)
				0: word = ENTRIES;
				1: word = $urandom_range(16, 1);
				2: word = $urandom_range(255, 17);
				3: word = $urandom;
				4: word = (ph < 6) ? 32'd0 : 32'h0000_01ff;
				default: word = ENTRIES - 1;
			endcase
			calm = (ph == 6 || ph == 7);
			write_count(word);
			items = (cur_count == 0) ? 20 : PHASE_ITEMS;
			repeat (items) send_random();
		end
		calm = 1'b0;
		s_tvalid = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("palette_gradient_table_top regression: pass");
		else
			$display("palette_gradient_table_top regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/pgt_pkg.sv
hw/rtl/palette_gradient_table_top.sv
tb/palette_result_check.sv
tb/palette_gradient_table_top_test.sv
